// File: hdl/dht_pkg.sv
// ---------------------------------------------------------------------------
// DHT edge decoder package
// Shared types, constants and helpers for the single-wire sensor decoder.
// ---------------------------------------------------------------------------
package dht_pkg;

   // Field widths
   localparam int LineW   = 6;
   localparam int TimeW   = 32;
   localparam int CountW  = 6;
   localparam int ValueW  = 16;
   localparam int FrameBits = 40;

   localparam logic [LineW-1:0]  WatchedLineReset = 6'd4;
   localparam logic [CountW-1:0] CountMax         = '1;

   // Timing windows in microseconds, both ends inclusive
   localparam logic [TimeW-1:0] StartLo     = 32'd950;
   localparam logic [TimeW-1:0] StartHi     = 32'd1100;
   localparam logic [TimeW-1:0] PullupLo    = 32'd16;
   localparam logic [TimeW-1:0] PullupHi    = 32'd44;
   localparam logic [TimeW-1:0] ResponseLo  = 32'd76;
   localparam logic [TimeW-1:0] ResponseHi  = 32'd84;
   localparam logic [TimeW-1:0] DataStartLo = 32'd46;
   localparam logic [TimeW-1:0] DataStartHi = 32'd74;
   localparam logic [TimeW-1:0] ZeroLo      = 32'd22;
   localparam logic [TimeW-1:0] ZeroHi      = 32'd32;
   localparam logic [TimeW-1:0] OneLo       = 32'd66;
   localparam logic [TimeW-1:0] OneHi       = 32'd74;

   localparam logic [ValueW-2:0] MagnitudeMask = 15'h7fff;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_START        = 3'd0,
      PH_PULLUP_START = 3'd1,
      PH_RESPONSE     = 3'd2,
      PH_PULLUP_RESP  = 3'd3,
      PH_DATA_START   = 3'd4,
      PH_DATA_VALUE   = 3'd5
   } phase_type;

   // Report status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SIGNAL = 2'd1,
      ST_SHORT     = 2'd2,
      ST_CHECKSUM  = 2'd3
   } status_type;

   // Transaction handed from the input register to the capture logic
   typedef struct packed {
      logic                go;
      logic                finish;
      logic [LineW-1:0]    line_number;
      logic [TimeW-1:0]    edge_time;
      logic                level_high;
   } cap_ctrl_type;

   // True when v lies within lo..hi inclusive.
   function automatic logic in_window(input logic [TimeW-1:0] v,
                                      input logic [TimeW-1:0] lo,
                                      input logic [TimeW-1:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

endpackage

// File: hdl/dht_capture.sv
// ---------------------------------------------------------------------------
// DHT edge capture
// Phase machine, edge timestamp and frame shift register of the decoder.
// ---------------------------------------------------------------------------
module dht_capture
   import dht_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cap_ctrl_type         ctrl,
   input  logic [LineW-1:0]     watched_line,
   output logic [FrameBits-1:0] frame_bits,
   output logic [CountW-1:0]    bit_count
);

   phase_type              phase_ff, phase_in;
   logic [TimeW-1:0]       last_time_ff, last_time_in;
   logic [FrameBits-1:0]   frame_ff, frame_in;
   logic [CountW-1:0]      count_ff, count_in;
   logic [TimeW-1:0]       delta;
   logic                   take_bit;
   logic                   bit_value;

   // Time since the previous edge, wrapping
   assign delta = ctrl.edge_time - last_time_ff;

   // Next phase and capture state
   always_comb begin
      phase_in     = phase_ff;
      last_time_in = last_time_ff;
      frame_in     = frame_ff;
      count_in     = count_ff;
      take_bit     = 1'b0;
      bit_value    = 1'b0;
      if (ctrl.go) begin
         if (ctrl.finish) begin
            phase_in     = PH_START;
            last_time_in = '0;
            frame_in     = '0;
            count_in     = '0;
         end else if (ctrl.line_number == watched_line) begin
            last_time_in = ctrl.edge_time;
            unique case (phase_ff)
               PH_PULLUP_START: begin
                  if (!ctrl.level_high && in_window(delta, PullupLo, PullupHi))
                     phase_in = PH_RESPONSE;
               end
               PH_RESPONSE: begin
                  if (ctrl.level_high && in_window(delta, ResponseLo, ResponseHi))
                     phase_in = PH_PULLUP_RESP;
               end
               PH_PULLUP_RESP: begin
                  if (!ctrl.level_high && in_window(delta, ResponseLo, ResponseHi))
                     phase_in = PH_DATA_START;
               end
               PH_DATA_START: begin
                  if (ctrl.level_high && in_window(delta, DataStartLo, DataStartHi))
                     phase_in = PH_DATA_VALUE;
               end
               PH_DATA_VALUE: begin
                  if (!ctrl.level_high && in_window(delta, ZeroLo, ZeroHi)) begin
                     take_bit = 1'b1;
                  end else if (!ctrl.level_high && in_window(delta, OneLo, OneHi)) begin
                     take_bit  = 1'b1;
                     bit_value = 1'b1;
                  end
               end
               default: begin
                  if (ctrl.level_high && in_window(delta, StartLo, StartHi))
                     phase_in = PH_PULLUP_START;
               end
            endcase

            // A decoded bit is kept only while the frame has room; the count saturates.
            if (take_bit) begin
               if (count_ff < CountW'(FrameBits))
                  frame_in = {frame_ff[FrameBits-2:0], bit_value};
               if (count_ff != CountMax)
                  count_in = count_ff + 1'b1;
               phase_in = PH_DATA_START;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         last_time_ff <= '0;
         frame_ff     <= '0;
         count_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         last_time_ff <= last_time_in;
         frame_ff     <= frame_in;
         count_ff     <= count_in;
      end
   end

   assign frame_bits = frame_ff;
   assign bit_count  = count_ff;

endmodule

// File: hdl/dht22_edge_timing_decoder.sv
// ---------------------------------------------------------------------------
// DHT22 edge timing decoder
// Decodes timestamped edge events of a single-wire sensor line into reports.
// ---------------------------------------------------------------------------
// Usage:
// The req_ stream carries one transaction per edge event or finish request;
// tuser selects the kind (0 edge, 1 finish). Edges on lines other than the
// watched line are ignored. Edge transactions produce no output; each finish
// transaction produces one rsp_ transaction with the status in tuser and the
// temperature and humidity in tenths in tdata, then clears the capture.
// An accepted transaction sits in the input register and is decoded from there
// into the capture state and, for a finish, into the result register, which
// offers the report. One transaction is taken per cycle while no finish waits
// on a held report; the rate is set by the single decode stage between the
// input and result registers. When the receiver stalls, the report is held
// and the input register keeps accepting edge transactions; a second finish
// waits in the input register until the held report is taken. Reset empties
// both registers, clears the capture state and sets the watched line to 4.
// The csr_ port holds the watched line at every address; write it only while
// the decoder is idle.
// ---------------------------------------------------------------------------
module dht22_edge_timing_decoder
   import dht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [5:0] line_number, [37:6] edge_time,
                                    // [38] level_high, [39] zero
   input  logic        req_tuser,   // [0] action
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] temperature_tenths,
                                    // [31:16] humidity_tenths
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [LineW-1:0]      watched_ff;
   logic                  in_valid_ff;
   logic                  in_finish_ff;
   logic [LineW-1:0]      in_line_ff;
   logic [TimeW-1:0]      in_time_ff;
   logic                  in_level_ff;
   logic                  proc_go;
   logic                  req_fire;
   cap_ctrl_type          cap_ctrl;
   logic [FrameBits-1:0]  frame_bits;
   logic [CountW-1:0]     bit_count;
   logic [7:0]            checksum;
   logic [ValueW-2:0]     magnitude;
   status_type            status_in;
   logic [ValueW-1:0]     temp_in;
   logic [ValueW-1:0]     hum_in;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [ValueW-1:0]     rsp_temp_ff;
   logic [ValueW-1:0]     rsp_hum_ff;

   // Register port: a single register, so every address selects it.
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-LineW){1'b0}}, watched_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_ff <= WatchedLineReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         watched_ff <= csr_pwdata[LineW-1:0];
      end
   end

   // The held item decodes unless it is a finish and the result slot is still full.
   assign proc_go    = in_valid_ff && (!in_finish_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_go;
   assign req_fire   = req_tvalid && req_tready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_finish_ff <= req_tuser;
         in_line_ff   <= req_tdata[LineW-1:0];
         in_time_ff   <= req_tdata[LineW+TimeW-1:LineW];
         in_level_ff  <= req_tdata[LineW+TimeW];
      end
   end

   assign cap_ctrl = '{go:          proc_go,
                       finish:      in_finish_ff,
                       line_number: in_line_ff,
                       edge_time:   in_time_ff,
                       level_high:  in_level_ff};

   dht_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (cap_ctrl),
      .watched_line (watched_ff),
      .frame_bits   (frame_bits),
      .bit_count    (bit_count)
   );

   // Report from the captured frame
   assign checksum  = frame_bits[39:32] + frame_bits[31:24]
                    + frame_bits[23:16] + frame_bits[15:8];
   assign magnitude = frame_bits[22:8] & MagnitudeMask;

   always_comb begin
      status_in = ST_OK;
      temp_in   = '0;
      hum_in    = '0;
      if (bit_count == '0) begin
         status_in = ST_NO_SIGNAL;
      end else if (bit_count < CountW'(FrameBits)) begin
         status_in = ST_SHORT;
      end else if (frame_bits[7:0] != checksum) begin
         status_in = ST_CHECKSUM;
      end else begin
         if (frame_bits[23])
            temp_in = ValueW'(0) - {1'b0, magnitude};
         else
            temp_in = {1'b0, magnitude};
         hum_in = frame_bits[39:24];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_go && in_finish_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && in_finish_ff) begin
         rsp_status_ff <= status_in;
         rsp_temp_ff   <= temp_in;
         rsp_hum_ff    <= hum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_hum_ff, rsp_temp_ff};

endmodule
